FILE: hdl/apq_pkg.sv
// apq_pkg: shared types and constants of the ascending priority queue
// holds the item structs, the queue capacity and the action and status codes
// no dependencies
`default_nettype none

package apq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_DROPPED = 2'd2;

  typedef struct packed {
    logic       action;
    logic [7:0] item_value;
    logic [7:0] item_priority;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic [1:0] status;
    logic [4:0] entry_count;
    logic       is_empty;
    logic [7:0] front_value;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/apq_ctrl.sv
// apq_ctrl: controller of the priority queue, sequences capture and update
// depends on apq_pkg
`default_nettype none

module apq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output logic               out_valid,
  output apq_pkg::cmd_t      cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
          busy_nxt  = 1'b1;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        busy_nxt  = 1'b0;
        valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy        = busy_r;
  assign out_valid   = valid_r;
  assign cmd.capture = start && !busy_r;
  assign cmd.exec    = (state_r == ST_EXEC);

endmodule

`default_nettype wire

FILE: hdl/apq_datapath.sv
// apq_datapath: sorted slot row with parallel compare and one-step shift
// holds the item register, slots, count and result register; depends on apq_pkg
`default_nettype none

module apq_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire apq_pkg::cmd_t       cmd,
  input  wire apq_pkg::in_item_t   in_item,
  output apq_pkg::out_item_t       out_item
);

  localparam int CAP = apq_pkg::CAPACITY;

  apq_pkg::in_item_t  req_r;
  apq_pkg::out_item_t res_r, res_nxt;

  logic [7:0] val_r   [CAP];
  logic [7:0] pri_r   [CAP];
  logic [7:0] val_nxt [CAP];
  logic [7:0] pri_nxt [CAP];
  logic [apq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [CAP-1:0] ge;
  logic full, empty;

  assign full  = (count_r == apq_pkg::CNT_W'(CAP));
  assign empty = (count_r == '0);

  // slots at or past the insert point
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      ge[i] = (apq_pkg::CNT_W'(i) >= count_r) || (pri_r[i] > req_r.item_priority);
    end
  end

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      val_nxt[i] = val_r[i];
      pri_nxt[i] = pri_r[i];
    end
    count_nxt       = count_r;
    res_nxt         = '0;
    res_nxt.status  = apq_pkg::STATUS_DONE;
    if (req_r.action == apq_pkg::ACT_ENQUEUE) begin
      if (full) begin
        res_nxt.status = apq_pkg::STATUS_DROPPED;
      end else begin
        for (int i = 0; i < CAP; i++) begin
          if (ge[i]) begin
            if (i > 0 && ge[(i > 0) ? i - 1 : 0]) begin
              val_nxt[i] = val_r[(i > 0) ? i - 1 : 0];
              pri_nxt[i] = pri_r[(i > 0) ? i - 1 : 0];
            end else begin
              val_nxt[i] = req_r.item_value;
              pri_nxt[i] = req_r.item_priority;
            end
          end
        end
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (empty) begin
        res_nxt.status = apq_pkg::STATUS_EMPTY;
      end else begin
        res_nxt.out_value = val_r[0];
        for (int i = 0; i < CAP - 1; i++) begin
          val_nxt[i] = val_r[i + 1];
          pri_nxt[i] = pri_r[i + 1];
        end
        count_nxt = count_r - 1'b1;
      end
    end
    res_nxt.entry_count = 5'(count_nxt);
    res_nxt.is_empty    = (count_nxt == '0);
    res_nxt.front_value = (count_nxt == '0) ? 8'd0 : val_nxt[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_item;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
      for (int i = 0; i < CAP; i++) begin
        val_r[i] <= val_nxt[i];
        pri_r[i] <= pri_nxt[i];
      end
    end
  end

  assign out_item = res_r;

endmodule

`default_nettype wire

FILE: hdl/ascending_priority_queue_core.sv
// ascending_priority_queue_core: top level of the ascending priority queue
// instantiates apq_ctrl and apq_datapath; depends on apq_pkg
//
// An item is taken when start is high and busy is low. Each item is first
// captured into the item register; then every slot compares its priority
// against the new one in parallel and the whole slot row shifts in a single
// step. The result appears with out_valid for exactly one cycle in the cycle
// after the update, and a new item may be started in that same cycle. The
// receiver cannot stall: a result must be taken when out_valid is high.
// Enqueue on a full queue is dropped with a dropped status; dequeue on an
// empty queue returns 0 with an empty status. No clearing pass after reset.
`default_nettype none

module ascending_priority_queue_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire apq_pkg::in_item_t   in_item,
  output logic                     out_valid,
  output apq_pkg::out_item_t       out_item
);

  apq_pkg::cmd_t cmd;

  apq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  apq_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

FILE: tb/ascending_priority_queue_core_tb.sv
// ascending_priority_queue_core_tb: self-checking bench for the ascending priority queue
// directed table then burst-biased random items, checked against table values or a shadow queue
// depends on apq_pkg and ascending_priority_queue_core
`default_nettype none

module ascending_priority_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import apq_pkg::*;

  typedef struct packed {
    in_item_t  item;
    logic      known;
    out_item_t want;
  } dir_row_t;

  localparam int DIR_ROWS   = 22;
  localparam int RAND_ITEMS = 1430;
  localparam int BURST_LEN  = 24;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  logic      row_known = 1'b0;
  out_item_t row_want = '0;
  bit        failed = 1'b0;

  logic [7:0] shadow_val [CAPACITY];
  logic [7:0] shadow_pri [CAPACITY];
  int         shadow_count = 0;
  out_item_t  pq_outcomes [$];

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{ACT_DEQUEUE, 8'h00, 8'h00}, 1'b1, '{8'h00, STATUS_EMPTY,   5'd0,  1'b1, 8'h00}},
    '{'{ACT_ENQUEUE, 8'hAB, 8'h80}, 1'b1, '{8'h00, STATUS_DONE,    5'd1,  1'b0, 8'hAB}},
    '{'{ACT_ENQUEUE, 8'h00, 8'hFF}, 1'b1, '{8'h00, STATUS_DONE,    5'd2,  1'b0, 8'hAB}},
    '{'{ACT_ENQUEUE, 8'hFF, 8'h00}, 1'b1, '{8'h00, STATUS_DONE,    5'd3,  1'b0, 8'hFF}},
    '{'{ACT_ENQUEUE, 8'h11, 8'h00}, 1'b0, '0},
    '{'{ACT_ENQUEUE, 8'h22, 8'h80}, 1'b0, '0},
    '{'{ACT_ENQUEUE, 8'h33, 8'hFF}, 1'b0, '0},
    '{'{ACT_ENQUEUE, 8'h44, 8'h7F}, 1'b0, '0},
    '{'{ACT_ENQUEUE, 8'h55, 8'h81}, 1'b0, '0},
    '{'{ACT_ENQUEUE, 8'h66, 8'h01}, 1'b0, '0},
    '{'{ACT_ENQUEUE, 8'h77, 8'hFE}, 1'b0, '0},
    '{'{ACT_ENQUEUE, 8'h88, 8'h00}, 1'b0, '0},
    '{'{ACT_ENQUEUE, 8'h99, 8'h40}, 1'b0, '0},
    '{'{ACT_ENQUEUE, 8'hAA, 8'hC0}, 1'b0, '0},
    '{'{ACT_ENQUEUE, 8'hBB, 8'h80}, 1'b0, '0},
    '{'{ACT_ENQUEUE, 8'hCC, 8'hFF}, 1'b0, '0},
    '{'{ACT_ENQUEUE, 8'h5A, 8'h00}, 1'b1, '{8'h00, STATUS_DONE,    5'd16, 1'b0, 8'hFF}},
    '{'{ACT_ENQUEUE, 8'h5B, 8'h00}, 1'b1, '{8'h00, STATUS_DROPPED, 5'd16, 1'b0, 8'hFF}},
    '{'{ACT_DEQUEUE, 8'h00, 8'h00}, 1'b1, '{8'hFF, STATUS_DONE,    5'd15, 1'b0, 8'h11}},
    '{'{ACT_DEQUEUE, 8'hFF, 8'hFF}, 1'b0, '0},
    '{'{ACT_DEQUEUE, 8'h0F, 8'hF0}, 1'b0, '0},
    '{'{ACT_DEQUEUE, 8'hF0, 8'h0F}, 1'b0, '0}
  };

  ascending_priority_queue_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  function automatic out_item_t pq_apply(input in_item_t it);
    out_item_t r;
    int        pos;
    int        i;
    r = '0;
    if (it.action == ACT_ENQUEUE) begin
      if (shadow_count >= CAPACITY) begin
        r.status = STATUS_DROPPED;
      end else begin
        pos = shadow_count;
        for (i = 0; i < shadow_count; i++) begin
          if (pos == shadow_count && shadow_pri[i] > it.item_priority) begin
            pos = i;
          end
        end
        for (i = shadow_count; i > pos; i--) begin
          shadow_val[i] = shadow_val[i-1];
          shadow_pri[i] = shadow_pri[i-1];
        end
        shadow_val[pos] = it.item_value;
        shadow_pri[pos] = it.item_priority;
        shadow_count++;
        r.status = STATUS_DONE;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.out_value = shadow_val[0];
        for (i = 1; i < shadow_count; i++) begin
          shadow_val[i-1] = shadow_val[i];
          shadow_pri[i-1] = shadow_pri[i];
        end
        shadow_count--;
        r.status = STATUS_DONE;
      end
    end
    r.entry_count = shadow_count[4:0];
    r.is_empty    = (shadow_count == 0);
    r.front_value = (shadow_count == 0) ? 8'h00 : shadow_val[0];
    return r;
  endfunction

  function automatic in_item_t rand_item(input int unsigned enq_pct);
    in_item_t it;
    it.action     = ($urandom_range(99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
    it.item_value = 8'($urandom);
    case ($urandom_range(3))
      0: it.item_priority = 8'($urandom_range(3));
      1: it.item_priority = $urandom_range(1) ? 8'hFF : 8'h00;
      default: it.item_priority = 8'($urandom);
    endcase
    return it;
  endfunction

  task automatic offer(input in_item_t it, input logic known, input out_item_t want,
                       input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    in_item   <= it;
    row_known <= known;
    row_want  <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pq_outcomes.size() != 0);
  endtask

  always @(posedge clk) begin : monitor
    out_item_t calc;
    out_item_t due;
    if (rst_n) begin
      if (start && !busy) begin
        calc = pq_apply(in_item);
        pq_outcomes.push_back(row_known ? row_want : calc);
      end
      if (out_valid) begin
        if (pq_outcomes.size() == 0) begin
          $error("result with nothing pending: %p", out_item);
          failed = 1'b1;
        end else begin
          due = pq_outcomes.pop_front();
          if (out_item.out_value !== due.out_value) begin
            $error("out_value: expected %0h, got %0h", due.out_value, out_item.out_value);
            failed = 1'b1;
          end
          if (out_item.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_item.status);
            failed = 1'b1;
          end
          if (out_item.entry_count !== due.entry_count) begin
            $error("entry_count: expected %0d, got %0d", due.entry_count,
                   out_item.entry_count);
            failed = 1'b1;
          end
          if (out_item.is_empty !== due.is_empty) begin
            $error("is_empty: expected %0b, got %0b", due.is_empty, out_item.is_empty);
            failed = 1'b1;
          end
          if (out_item.front_value !== due.front_value) begin
            $error("front_value: expected %0h, got %0h", due.front_value,
                   out_item.front_value);
            failed = 1'b1;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned idle_pct [3];
    int unsigned enq_pct;
    int          ph;
    int          n;
    idle_pct = '{10, 50, 0};
    enq_pct  = 50;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (n = 0; n < DIR_ROWS; n++) begin
      offer(dir_rows[n].item, dir_rows[n].known, dir_rows[n].want, 0);
    end
    drain();

    for (ph = 0; ph < 3; ph++) begin
      for (n = 0; n < RAND_ITEMS / 3; n++) begin
        // bias each burst so the queue swings between empty and full
        if (n % BURST_LEN == 0) begin
          case ($urandom_range(2))
            0: enq_pct = 15;
            1: enq_pct = 50;
            default: enq_pct = 85;
          endcase
        end
        offer(rand_item(enq_pct), 1'b0, '0, idle_pct[ph]);
      end
      drain();
    end

    repeat (6) @(posedge clk);
    if (failed || pq_outcomes.size() != 0) begin
      $display("tb: failure");
    end else begin
      $display("tb: success");
    end
    $finish;
  end

  initial begin : watchdog
    #500us;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
